@@ sv/lmt_pkg.sv @@
// Package for the local midpoint threshold block: register indexes, fixed widths,
// and the command and status structs that pass between controller and datapath.
// No dependencies.
package lmt_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_CFG_W   = 11;
  localparam int FH_CFG_W   = 13;
  localparam int WS_CFG_W   = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

  localparam logic [FW_CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [WS_CFG_W-1:0] WINDOW_SIZE_RST  = 4'd3;

  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic latch;
    logic calc;
    logic update;
    logic start;
    logic scan;
    logic centre;
    logic decide;
    logic emit;
  } lmt_cmd_t;

  typedef struct packed {
    logic due;
    logic scan_last;
    logic out_free;
  } lmt_status_t;

endpackage

@@ sv/lmt_in_if.sv @@
// Input channel of the local midpoint threshold block: command and pixel.
// Depends on lmt_pkg.
interface lmt_in_if import lmt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output command, output pixel, input ready);
  modport sink   (input valid, input command, input pixel, output ready);
endinterface

@@ sv/lmt_out_if.sv @@
// Result channel of the local midpoint threshold block.
// No dependencies.
interface lmt_out_if #(
  parameter int COL_W = 10,
  parameter int ROW_W = 12
) ();
  logic             valid;
  logic             ready;
  logic             is_foreground;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row_index;
  logic             frame_last;

  modport source (output valid, output is_foreground, output column, output row_index,
                  output frame_last, input ready);
  modport sink   (input valid, input is_foreground, input column, input row_index,
                  input frame_last, output ready);
endinterface

@@ sv/lmt_cfg_if.sv @@
// Configuration write channel of the local midpoint threshold block.
// Depends on lmt_pkg.
interface lmt_cfg_if import lmt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/local_midpoint_threshold_top.sv @@
// Local midpoint adaptive threshold: binarizes a raster stream of 8-bit pixels
// against the midpoint of the max and min over a clipped square window.
// in_if (sink) takes command and pixel; command high is a drain step.
// out_if (source) gives is_foreground, column, row_index and frame_last.
// cfg_if (sink) writes frame_width, frame_height, window_size by index; always ready.
// One transaction at a time: an item that yields no result passes through the
// latch, calc, update and check states before the next ready; one that yields a
// result goes on through the start, scan, centre and decide states and is loaded
// into the output register at emit, the window of up to 225 in-frame pixels being
// read one pixel a cycle through the single row store port.
// Results trail the inputs by h rows and h pixels (h = half window); drain steps
// flush them after the frame. The last result of a frame carries frame_last and
// all position counters return to zero.
// Reset clears the counters and loads 640 x 480 with window 3; the row store
// needs no clearing. While the receiver stalls, the result stays in the output
// register; the block still takes items that yield no result, holds the next
// result until the output register frees and keeps the input stalled meanwhile.
// Depends on lmt_pkg, the channel interfaces, lmt_ctrl, lmt_dp and lmt_ram.
module local_midpoint_threshold_top import lmt_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_WINDOW = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  lmt_in_if.sink   in_if,
  lmt_out_if.source out_if,
  lmt_cfg_if.sink  cfg_if
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = 2 ** $clog2(MAX_WIDTH * MAX_WINDOW + MAX_WINDOW);
  localparam int AW    = $clog2(DEPTH);

  // configuration registers
  logic [FW_CFG_W-1:0] frame_width_r;
  logic [FH_CFG_W-1:0] frame_height_r;
  logic [WS_CFG_W-1:0] window_size_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      window_size_r  <= WINDOW_SIZE_RST;
    end else if (cfg_if.valid) begin
      // drop writes to indexes beyond the register list
      unique case (cfg_if.index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_if.data[FW_CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_if.data[FH_CFG_W-1:0];
        REG_WINDOW_SIZE:  window_size_r  <= cfg_if.data[WS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  lmt_cmd_t    cmd;
  lmt_status_t status;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [PIX_W-1:0]    ram_wdata, ram_rdata;

  lmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lmt_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW),
    .CW         (CW),
    .RW         (RW),
    .AW         (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_command (in_if.command),
    .in_pixel   (in_if.pixel),
    .cfg_width  (frame_width_r),
    .cfg_height (frame_height_r),
    .cfg_window (window_size_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_fg     (out_if.is_foreground),
    .out_col    (out_if.column),
    .out_row    (out_if.row_index),
    .out_last   (out_if.frame_last)
  );

  // row store, addressed by raster index modulo its depth
  lmt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second transaction accepted while busy");

endmodule

@@ sv/lmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lmt_ctrl.sv @@
// Sequencer of the local midpoint threshold block: walks one transaction through
// position update, window scan and result hand-off. Depends on lmt_pkg.
module lmt_ctrl import lmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lmt_status_t status,
  output lmt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_UPD, S_CHK, S_START, S_SCAN, S_CENT, S_DEC, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_CHK;
      S_CHK:   state_nxt = status.due ? S_START : S_IDLE;
      S_START: state_nxt = S_SCAN;
      S_SCAN:  if (status.scan_last) state_nxt = S_CENT;
      S_CENT:  state_nxt = S_DEC;
      S_DEC:   state_nxt = S_EMIT;
      S_EMIT:  if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.latch  = (state_r == S_IDLE) && in_valid;
  assign cmd.calc   = (state_r == S_CALC);
  assign cmd.update = (state_r == S_UPD);
  assign cmd.start  = (state_r == S_START);
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.centre = (state_r == S_CENT);
  assign cmd.decide = (state_r == S_DEC);
  assign cmd.emit   = (state_r == S_EMIT) && status.out_free;

endmodule

@@ sv/lmt_dp.sv @@
// Datapath of the local midpoint threshold block: position counters, raster
// arithmetic, window walk, max/min and the output register. Depends on lmt_pkg.
module lmt_dp import lmt_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_WINDOW = 15,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT),
  parameter int AW         = $clog2(MAX_WIDTH * MAX_WINDOW + MAX_WINDOW)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lmt_cmd_t            cmd,
  output lmt_status_t         status,
  input  logic                in_command,
  input  logic [PIX_W-1:0]    in_pixel,
  input  logic [FW_CFG_W-1:0] cfg_width,
  input  logic [FH_CFG_W-1:0] cfg_height,
  input  logic [WS_CFG_W-1:0] cfg_window,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [PIX_W-1:0]    ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [PIX_W-1:0]    ram_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_fg,
  output logic [CW-1:0]       out_col,
  output logic [RW-1:0]       out_row,
  output logic                out_last
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HGW  = $clog2(MAX_HEIGHT + 1);
  localparam int HMAX = (MAX_WINDOW - 1) / 2;
  localparam int HW   = $clog2(HMAX + 1);
  localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1) + 1;

  // effective sizes
  logic [WW-1:0]  w_eff;
  logic [HGW-1:0] hg_eff;
  logic [HW-1:0]  h_eff;
  logic [WS_CFG_W-1:0] h_raw;

  always_comb begin
    if (cfg_width == '0) w_eff = WW'(1);
    else if (32'(cfg_width) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_width);
    if (cfg_height == '0) hg_eff = HGW'(1);
    else if (32'(cfg_height) > 32'(MAX_HEIGHT)) hg_eff = HGW'(MAX_HEIGHT);
    else hg_eff = HGW'(cfg_height);
    h_raw = (cfg_window == '0) ? '0 : ((cfg_window - WS_CFG_W'(1)) >> 1);
    if (32'(h_raw) > 32'(HMAX)) h_eff = HW'(HMAX);
    else h_eff = HW'(h_raw);
  end

  logic             cmd_r;
  logic [PIX_W-1:0] pix_r;
  logic [WW-1:0]    w_r;
  logic [HGW-1:0]   hg_r;
  logic [HW-1:0]    h_r;
  logic [PW-1:0]    total_r, n_r, k_r, lag_r;
  logic [CW-1:0]    in_col_r, oc_r;
  logic [HGW-1:0]   in_row_r;
  logic [RW-1:0]    or_r;
  logic             due_r;
  logic [RW-1:0]    r0_r, r1_r, rr_r;
  logic [CW-1:0]    c0_r, c1_r, cc_r;
  logic [PW-1:0]    base_r;
  logic             acc_r;
  logic [PIX_W-1:0] mx_r, mn_r;
  logic             fg_r, last_r;
  logic             out_valid_r;

  // position update after an optional end-of-frame restart
  logic           clr, wr, due;
  logic [PW-1:0]  n0, k0, n1;
  logic [CW-1:0]  ic0, oc0;
  logic [HGW-1:0] ir0;
  logic [RW-1:0]  or0;
  logic [PW-1:0]  or_p, oc_p, h_p;

  always_comb begin
    clr  = (k_r >= total_r);
    n0   = clr ? '0 : n_r;
    k0   = clr ? '0 : k_r;
    ic0  = clr ? '0 : in_col_r;
    ir0  = clr ? '0 : in_row_r;
    oc0  = clr ? '0 : oc_r;
    or0  = clr ? '0 : or_r;
    wr   = (cmd_r != CMD_DRAIN) && (n0 < total_r);
    n1   = n0 + PW'(wr);
    due  = (k0 < total_r) && ((k0 + lag_r < n1) || (n1 >= total_r));
    or_p = PW'(or0);
    oc_p = PW'(oc0);
    h_p  = PW'(h_r);
  end

  assign status.due       = due_r;
  assign status.scan_last = (rr_r == r1_r) && (cc_r == c1_r);
  assign status.out_free  = !out_valid_r || out_ready;

  assign ram_we    = cmd.update && wr;
  assign ram_waddr = AW'(n0);
  assign ram_wdata = pix_r;
  assign ram_re    = cmd.scan || cmd.centre;
  assign ram_raddr = cmd.centre ? AW'(k_r) : AW'(base_r + PW'(cc_r));

  logic [PIX_W:0] mid_sum;
  assign mid_sum = {1'b0, mx_r} + {1'b0, mn_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      oc_r        <= '0;
      or_r        <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
      due_r       <= 1'b0;
    end else begin
      acc_r <= cmd.scan;
      if (cmd.update) begin
        due_r <= due;
        oc_r  <= oc0;
        or_r  <= or0;
        if (wr) begin
          if (WW'(ic0) + WW'(1) >= w_r) begin
            in_col_r <= '0;
            in_row_r <= ir0 + HGW'(1);
          end else begin
            in_col_r <= ic0 + CW'(1);
            in_row_r <= ir0;
          end
        end else begin
          in_col_r <= ic0;
          in_row_r <= ir0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          in_col_r <= '0;
          in_row_r <= '0;
          oc_r     <= '0;
          or_r     <= '0;
        end else if (WW'(oc_r) + WW'(1) >= w_r) begin
          oc_r <= '0;
          or_r <= or_r + RW'(1);
        end else begin
          oc_r <= oc_r + CW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_command;
      pix_r <= in_pixel;
    end
    if (cmd.calc) begin
      w_r     <= w_eff;
      hg_r    <= hg_eff;
      h_r     <= h_eff;
      total_r <= PW'(w_eff) * PW'(hg_eff);
      n_r     <= PW'(in_row_r) * PW'(w_eff) + PW'(in_col_r);
      k_r     <= PW'(or_r) * PW'(w_eff) + PW'(oc_r);
      lag_r   <= PW'(h_eff) * PW'(w_eff) + PW'(h_eff);
    end
    if (cmd.update) begin
      k_r  <= k0;
      r0_r <= (or_p >= h_p) ? RW'(or_p - h_p) : '0;
      r1_r <= (or_p + h_p < PW'(hg_r)) ? RW'(or_p + h_p) : RW'(PW'(hg_r) - PW'(1));
      c0_r <= (oc_p >= h_p) ? CW'(oc_p - h_p) : '0;
      c1_r <= (oc_p + h_p < PW'(w_r)) ? CW'(oc_p + h_p) : CW'(PW'(w_r) - PW'(1));
    end
    if (cmd.start) begin
      base_r <= PW'(r0_r) * PW'(w_r);
      rr_r   <= r0_r;
      cc_r   <= c0_r;
      mx_r   <= '0;
      mn_r   <= PIX_MAX;
    end
    if (cmd.scan) begin
      if (cc_r == c1_r) begin
        cc_r   <= c0_r;
        rr_r   <= rr_r + RW'(1);
        base_r <= base_r + PW'(w_r);
      end else begin
        cc_r <= cc_r + CW'(1);
      end
    end
    if (acc_r) begin
      if (ram_rdata > mx_r) mx_r <= ram_rdata;
      if (ram_rdata < mn_r) mn_r <= ram_rdata;
    end
    if (cmd.decide) begin
      fg_r   <= ram_rdata > mid_sum[PIX_W:1];
      last_r <= (k_r + PW'(1) == total_r);
    end
    if (cmd.emit) begin
      out_fg   <= fg_r;
      out_col  <= oc_r;
      out_row  <= or_r;
      out_last <= last_r;
    end
  end

  assign out_valid = out_valid_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result register loaded while occupied");
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> (mn_r <= mx_r))
    else $error("window minimum above maximum");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.centre |-> acc_r)
    else $error("last window sample not accumulated");

endmodule
